[sv/brbu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brbu_pkg
// Shared types and constants of the burst byte ring buffer.
// ----------------------------------------------------------------------------
package brbu_pkg;

    localparam int LANES       = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FLUSH = 2'd2,
        OP_BAD   = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        miss;
        logic [3:0]  len;
        logic [63:0] data;
        logic [8:0]  stored;
        logic [8:0]  free;
    } t_cmd;

endpackage
`default_nettype wire

[sv/brbu_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brbu_front
// Accepts transactions, checks space and fill, advances the counters and
// hands a classified command with its start address to the queue.
// ----------------------------------------------------------------------------
module brbu_front
    import brbu_pkg::*;
#(
    parameter int BUFFER_BYTES = 256,
    parameter int MAX_BURST    = 8,
    parameter int IDX_W        = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_action,
    input  wire logic [3:0]        i_length,
    input  wire logic [63:0]       i_push_bytes,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output t_cmd                   o_cmd,
    output logic [IDX_W-1:0]       o_addr
);

    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = CNT_W + 4;

    logic [CNT_W-1:0] r_wr;
    logic [CNT_W-1:0] r_rd;
    logic [CNT_W-1:0] n_wr;
    logic [CNT_W-1:0] n_rd;
    logic [CNT_W-1:0] held;
    logic [CNT_W-1:0] free;
    logic [CNT_W-1:0] held_new;
    logic [CNT_W-1:0] free_new;
    logic             len_ok;
    logic             miss;
    logic             accept;
    t_op              op;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign o_q_push = accept;
    assign op       = t_op'(i_action);
    assign held     = r_wr - r_rd;
    assign free     = CNT_W'(BUFFER_BYTES) - held;
    assign len_ok   = CMP_W'(i_length) <= CMP_W'(MAX_BURST);

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        miss = 1'b0;
        unique case (op)
            OP_PUSH: begin
                if (!len_ok || (CMP_W'(i_length) > CMP_W'(free))) begin
                    miss = 1'b1;
                end else begin
                    n_wr = r_wr + CNT_W'(i_length);
                end
            end
            OP_POP: begin
                if (!len_ok || (CMP_W'(i_length) > CMP_W'(held))) begin
                    miss = 1'b1;
                end else begin
                    n_rd = r_rd + CNT_W'(i_length);
                end
            end
            OP_FLUSH: begin
                n_rd = r_wr;
            end
            default: begin
                miss = 1'b1;
            end
        endcase
    end

    assign held_new = n_wr - n_rd;
    assign free_new = CNT_W'(BUFFER_BYTES) - held_new;

    always_comb begin
        o_cmd.op     = op;
        o_cmd.miss   = miss;
        o_cmd.len    = i_length;
        o_cmd.data   = i_push_bytes;
        o_cmd.stored = 9'(held_new);
        o_cmd.free   = 9'(free_new);
        o_addr       = (op == OP_POP) ? r_rd[IDX_W-1:0] : r_wr[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else if (accept) begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) <= CNT_W'(BUFFER_BYTES))
        else $error("fill level beyond buffer size");

    a_miss_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && miss |=> $stable(r_wr) && $stable(r_rd))
        else $error("missed transaction moved a counter");
`endif

endmodule
`default_nettype wire

[sv/brbu_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brbu_queue
// Short command queue between the classifying front and the storage back.
// ----------------------------------------------------------------------------
module brbu_queue
    import brbu_pkg::*;
#(
    parameter int IDX_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  t_cmd                  i_cmd,
    input  wire logic [IDX_W-1:0] i_addr,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output t_cmd                  o_cmd,
    output logic [IDX_W-1:0]      o_addr
);

    t_cmd              r_cmd  [QUEUE_DEPTH];
    logic [IDX_W-1:0]  r_addr [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_cmd[r_head];
    assign o_addr  = r_addr[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_tail]  <= i_cmd;
            r_addr[r_tail] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue written when full or read when empty");
`endif

endmodule
`default_nettype wire

[sv/brbu_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brbu_back
// Byte-banked store: writes pushed bursts, reads popped bursts, aligns the
// popped lanes and holds the result for the output channel.
// ----------------------------------------------------------------------------
module brbu_back
    import brbu_pkg::*;
#(
    parameter int BUFFER_BYTES = 256,
    parameter int IDX_W        = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    output logic                  o_q_pop,
    input  t_cmd                  i_cmd,
    input  wire logic [IDX_W-1:0] i_addr,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_status,
    output logic [63:0]           o_pop_bytes,
    output logic [8:0]            o_stored_count,
    output logic [8:0]            o_free_space
);

    localparam int ROWS  = BUFFER_BYTES / LANES;
    localparam int ROW_W = (IDX_W > 3) ? IDX_W - 3 : 1;

    logic        issue;
    logic        out_free;
    logic        s1_adv;
    logic        wr_en;
    logic        rd_en;

    logic        r_s1_vld;
    t_op         r_s1_op;
    logic        r_s1_miss;
    logic [2:0]  r_s1_lo;
    logic [3:0]  r_s1_len;
    logic [8:0]  r_s1_stored;
    logic [8:0]  r_s1_free;
    logic [7:0]  r_bank_q [LANES];

    logic        r_o_vld;
    logic [63:0] popped;

    assign out_free = !r_o_vld || i_ready;
    assign s1_adv   = r_s1_vld && out_free;
    assign issue    = i_q_valid && (!r_s1_vld || s1_adv);
    assign o_q_pop  = issue;
    assign wr_en    = issue && (i_cmd.op == OP_PUSH) && !i_cmd.miss;
    assign rd_en    = issue && (i_cmd.op == OP_POP) && !i_cmd.miss;

    for (genvar b = 0; b < LANES; b++) begin : g_bank
        logic [7:0]       r_mem [ROWS];
        logic [2:0]       k;
        logic [IDX_W-1:0] addr_b;
        logic [ROW_W-1:0] row;
        logic             lane_en;

        assign k       = 3'(b) - i_addr[2:0];
        assign addr_b  = i_addr + IDX_W'(k);
        assign row     = ROW_W'(addr_b >> 3);
        assign lane_en = {1'b0, k} < i_cmd.len;

        always_ff @(posedge i_clk) begin
            if (wr_en && lane_en) begin
                r_mem[row] <= i_cmd.data[8*k +: 8];
            end
            if (rd_en) begin
                r_bank_q[b] <= r_mem[row];
            end
        end
    end

    always_comb begin
        logic [2:0] sel;
        popped = '0;
        for (int i = 0; i < LANES; i++) begin
            sel = r_s1_lo + 3'(i);
            if ((4'(i) < r_s1_len) && (r_s1_op == OP_POP) && !r_s1_miss) begin
                popped[8*i +: 8] = r_bank_q[sel];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_op     <= i_cmd.op;
            r_s1_miss   <= i_cmd.miss;
            r_s1_lo     <= i_addr[2:0];
            r_s1_len    <= i_cmd.len;
            r_s1_stored <= i_cmd.stored;
            r_s1_free   <= i_cmd.free;
        end
        if (s1_adv) begin
            o_status       <= r_s1_miss;
            o_pop_bytes    <= popped;
            o_stored_count <= r_s1_stored;
            o_free_space   <= r_s1_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_vld;

`ifndef NO_ASSERTIONS
    a_miss_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && o_status |-> o_pop_bytes == '0)
        else $error("missed transaction returned data");
`endif

endmodule
`default_nettype wire

[sv/byte_ring_buffer_burst_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_unit
// Burst byte FIFO: push, pop or flush of up to eight bytes per transaction.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while the four-entry command queue
// has room; its result then passes through the queue entry, the first back
// stage and the output register before it is presented. The
// front checks space and fill against free-running counters and updates them
// at once, so back-to-back transactions see each other's effect. The store is
// split into eight byte banks with one write or read row each per cycle,
// which lets any burst of up to eight bytes complete in a single access. A
// push or pop that does not fit reports a miss and changes nothing. Storage
// needs no clearing after reset.
module byte_ring_buffer_burst_unit
    import brbu_pkg::*;
#(
    parameter int BUFFER_BYTES = 256,
    parameter int MAX_BURST    = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_length,
    input  wire logic [63:0] i_push_bytes,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_status,
    output logic [63:0]      o_pop_bytes,
    output logic [8:0]       o_stored_count,
    output logic [8:0]       o_free_space
);

    localparam int IDX_W = $clog2(BUFFER_BYTES);

    logic             q_full;
    logic             q_push;
    logic             q_valid;
    logic             q_pop;
    t_cmd             f_cmd;
    t_cmd             q_cmd;
    logic [IDX_W-1:0] f_addr;
    logic [IDX_W-1:0] q_addr;

    brbu_front #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_BURST   (MAX_BURST),
        .IDX_W       (IDX_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_length    (i_length),
        .i_push_bytes(i_push_bytes),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_cmd       (f_cmd),
        .o_addr      (f_addr)
    );

    brbu_queue #(
        .IDX_W(IDX_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (f_cmd),
        .i_addr (f_addr),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_cmd  (q_cmd),
        .o_addr (q_addr)
    );

    brbu_back #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .IDX_W       (IDX_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_cmd         (q_cmd),
        .i_addr        (q_addr),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_pop_bytes   (o_pop_bytes),
        .o_stored_count(o_stored_count),
        .o_free_space  (o_free_space)
    );

endmodule
`default_nettype wire
